>>> rtl/llca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llca_pkg: shared constants and types of the least loaded core assigner
// Field widths, defaults and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package llca_pkg;

    localparam int DEF_MAX_CORES = 64;
    localparam int LOAD_W        = 32;
    localparam int THREAD_W      = 7;
    localparam int CFG_W         = 7;
    localparam int CORE_IDX_W    = 6;
    localparam int RESULT_LIMIT  = 64;
    localparam int DIV_STEPS     = LOAD_W;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

    localparam logic [CFG_W-1:0] CORES_RESET = CFG_W'(64);

    typedef struct packed {
        logic load;        // take a new job beat
        logic div_step;    // one quotient bit
        logic scan_issue;  // read the next core load
        logic write;       // commit the chosen core and emit a result
    } t_ctrl_cmd;

    typedef struct packed {
        logic zero_threads;
        logic div_done;
        logic scan_last;
        logic job_last;
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

>>> rtl/llca_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llca_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module llca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/llca_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llca_ctrl: sequencer of the least loaded core assigner
// Steps each job through the divide, then a scan and commit per placed thread.
// ----------------------------------------------------------------------------
module llca_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire llca_pkg::t_dp_status i_status,
    output llca_pkg::t_ctrl_cmd       o_cmd
);

    import llca_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_status.zero_threads) begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The last read comes back and is compared here.
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (i_status.out_free) begin
                    o_cmd.write = 1'b1;
                    n_state = i_status.job_last ? ST_IDLE : ST_SCAN;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

>>> rtl/llca_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llca_dp: datapath of the least loaded core assigner
// Share divider, core load memory with valid bits, minimum scan, saturating
// update and the result register.
// ----------------------------------------------------------------------------
module llca_dp #(
    parameter int MAX_CORES = llca_pkg::DEF_MAX_CORES
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire llca_pkg::t_ctrl_cmd                 i_cmd,
    output llca_pkg::t_dp_status                     o_status,
    input  wire logic [llca_pkg::CFG_W-1:0]          i_cores_in_use,
    input  wire logic [llca_pkg::THREAD_W-1:0]       i_thread_count,
    input  wire logic [llca_pkg::LOAD_W-1:0]         i_total_load,
    input  wire logic                                i_round_start,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic      [llca_pkg::CORE_IDX_W-1:0]     o_core_index,
    output logic                                     o_last_of_job,
    output logic                                     o_truncated
);

    import llca_pkg::*;

    localparam int IW = $clog2(MAX_CORES);
    localparam int CW = $clog2(MAX_CORES + 1);
    localparam int UW = CW + THREAD_W;

    // Job setup: usable cores and placed threads.
    logic [UW-1:0] u_cfg;
    logic [UW-1:0] u_thr;
    logic [UW-1:0] u_ncores;
    logic [UW-1:0] u_placed;

    always_comb begin
        u_cfg = UW'(i_cores_in_use);
        u_thr = UW'(i_thread_count);
        if (u_cfg == '0) begin
            u_ncores = UW'(1);
        end else if (u_cfg > UW'(MAX_CORES)) begin
            u_ncores = UW'(MAX_CORES);
        end else begin
            u_ncores = u_cfg;
        end
        u_placed = (u_thr < u_ncores) ? u_thr : u_ncores;
        if (u_placed > UW'(RESULT_LIMIT)) begin
            u_placed = UW'(RESULT_LIMIT);
        end
    end

    logic [CW-1:0]        r_ncores;
    logic [THREAD_W-1:0]  r_placed;
    logic                 r_trunc;
    logic [THREAD_W-1:0]  r_thread;

    // Restoring divider, one quotient bit per cycle; r_quo ends as the share.
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [THREAD_W-1:0]  r_divisor;
    logic [THREAD_W-1:0]  r_rem;
    logic [LOAD_W-1:0]    r_quo;
    logic [THREAD_W:0]    n_rem_sh;
    logic                 n_ge;
    logic [THREAD_W-1:0]  n_rem;

    always_comb begin
        n_rem_sh = {r_rem, r_quo[LOAD_W-1]};
        n_ge     = n_rem_sh >= {1'b0, r_divisor};
        n_rem    = n_ge ? THREAD_W'(n_rem_sh - {1'b0, r_divisor})
                        : n_rem_sh[THREAD_W-1:0];
    end

    // Scan over the core loads.
    logic [MAX_CORES-1:0] r_valid;
    logic [MAX_CORES-1:0] r_used;
    logic [IW-1:0]        r_addr;
    logic                 r_rvalid;
    logic [IW-1:0]        r_ridx;
    logic                 r_found;
    logic [IW-1:0]        r_best;
    logic [LOAD_W-1:0]    r_best_load;
    logic [LOAD_W-1:0]    rd_data;
    logic [LOAD_W-1:0]    n_load;
    logic                 n_take;
    logic [LOAD_W:0]      n_sum;
    logic [LOAD_W-1:0]    n_new_load;

    always_comb begin
        // An entry that was never written since the last clear reads as zero.
        n_load     = r_valid[r_ridx] ? rd_data : '0;
        n_take     = r_rvalid && !r_used[r_ridx] &&
                     (!r_found || (n_load < r_best_load));
        n_sum      = {1'b0, r_best_load} + {1'b0, r_quo};
        n_new_load = n_sum[LOAD_W] ? '1 : n_sum[LOAD_W-1:0];
    end

    llca_ram #(
        .WIDTH(LOAD_W),
        .DEPTH(MAX_CORES)
    ) u_load_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.write),
        .i_wr_addr (r_best),
        .i_wr_data (n_new_load),
        .i_rd_en   (i_cmd.scan_issue),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

    // Result register.
    logic                  r_out_valid;
    logic [CORE_IDX_W-1:0] r_core_index;
    logic                  r_last;
    logic                  r_out_trunc;

    always_comb begin
        o_status.zero_threads = (i_thread_count == '0);
        o_status.div_done     = (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
        o_status.scan_last    = (CW'(r_addr) == r_ncores - CW'(1));
        o_status.job_last     = (r_thread == r_placed - THREAD_W'(1));
        o_status.out_free     = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_used      <= '0;
            r_div_cnt   <= '0;
            r_rvalid    <= 1'b0;
            r_found     <= 1'b0;
            r_addr      <= '0;
            r_thread    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rvalid <= i_cmd.scan_issue;
            if (i_cmd.load) begin
                if (i_round_start) begin
                    r_valid <= '0;
                end
                r_used    <= '0;
                r_div_cnt <= '0;
                r_found   <= 1'b0;
                r_addr    <= '0;
                r_thread  <= '0;
            end
            if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
            end
            if (i_cmd.scan_issue && !o_status.scan_last) begin
                r_addr <= r_addr + IW'(1);
            end
            if (n_take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.write) begin
                r_valid[r_best] <= 1'b1;
                r_used[r_best]  <= 1'b1;
                r_found         <= 1'b0;
                r_addr          <= '0;
                r_thread        <= r_thread + THREAD_W'(1);
                r_out_valid     <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ncores  <= CW'(u_ncores);
            r_placed  <= THREAD_W'(u_placed);
            r_trunc   <= u_thr > u_placed;
            r_divisor <= i_thread_count;
            r_rem     <= '0;
            r_quo     <= i_total_load;
        end
        if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[LOAD_W-2:0], n_ge};
        end
        if (i_cmd.scan_issue) begin
            r_ridx <= r_addr;
        end
        if (n_take) begin
            r_best      <= r_ridx;
            r_best_load <= n_load;
        end
        if (i_cmd.write) begin
            r_core_index <= CORE_IDX_W'(r_best);
            r_last       <= o_status.job_last;
            r_out_trunc  <= r_trunc;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_core_index  = r_core_index;
    assign o_last_of_job = r_last;
    assign o_truncated   = r_out_trunc;

endmodule
`default_nettype wire

>>> rtl/least_loaded_core_assigner.sv
`timescale 1ns / 1ps
`default_nettype none
// A job is accepted in the idle state and divided bit by bit; then each placed
// thread gets a scan of the core loads and a commit, the commit waiting while
// the result register is full. A new job is accepted only after the last
// commit of the previous one; the scans are serial, set by the single read
// port of the core load memory.
// Reset clears all core loads at once and sets cores_in_use to 64.
// ----------------------------------------------------------------------------
// least_loaded_core_assigner: greedy least loaded core assignment
// Places the threads of a job, at most one per usable core, each on the least
// loaded core unused by the job, adding the job's per-thread load, saturating.
// ----------------------------------------------------------------------------
module least_loaded_core_assigner #(
    parameter int MAX_CORES = llca_pkg::DEF_MAX_CORES
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [llca_pkg::CFG_W-1:0]      i_cfg_cores_in_use,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [llca_pkg::THREAD_W-1:0]   i_thread_count,
    input  wire logic [llca_pkg::LOAD_W-1:0]     i_total_load,
    input  wire logic                            i_round_start,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic      [llca_pkg::CORE_IDX_W-1:0] o_core_index,
    output logic                                 o_last_of_job,
    output logic                                 o_truncated
);

    import llca_pkg::*;

    logic [CFG_W-1:0] r_cores_in_use;
    t_ctrl_cmd        cmd;
    t_dp_status       status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cores_in_use <= CORES_RESET;
        end else if (i_cfg_valid) begin
            r_cores_in_use <= i_cfg_cores_in_use;
        end
    end

    llca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    llca_dp #(
        .MAX_CORES(MAX_CORES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cores_in_use (r_cores_in_use),
        .i_thread_count (i_thread_count),
        .i_total_load   (i_total_load),
        .i_round_start  (i_round_start),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_core_index   (o_core_index),
        .o_last_of_job  (o_last_of_job),
        .o_truncated    (o_truncated)
    );

endmodule
`default_nettype wire

>>> tb/least_loaded_core_assigner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_loaded_core_assigner_tb: self-checking bench of the core assigner
// A directed table, then random jobs in several core-count settings.
// Each placement beat is checked against a predictor that keeps its own
// copy of the core loads, or against its typed-in outcome. Both sides idle
// at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module least_loaded_core_assigner_tb;
    import llca_pkg::*;

    localparam int NCORES      = DEF_MAX_CORES;
    localparam int SETTLE      = 64;
    localparam int HOLD_CYCLES = 700;
    localparam int PHASES      = 8;
    localparam int PHASE_JOBS  = 15;
    localparam int REPORT_MAX  = 10;

    typedef enum logic [1:0] {
        ROW_CFG,    // write cores_in_use
        ROW_JOB,    // job checked against the predictor
        ROW_KNOWN   // job with its outcome typed in
    } t_row_kind;

    typedef struct packed {
        logic [CORE_IDX_W-1:0] core;
        logic                  last;
        logic                  trunc;
    } t_placement;

    typedef struct {
        t_row_kind           kind;
        logic [THREAD_W-1:0] value;     // cores for ROW_CFG, thread count otherwise
        logic [LOAD_W-1:0]   load;
        logic                round;
        int                  n_known;   // 0 or 1 placement for ROW_KNOWN
        logic [CORE_IDX_W-1:0] core;
        logic                trunc;
    } t_stim_row;

    localparam int DIRECTED_N = 24;

    t_stim_row directed_rows [DIRECTED_N] = '{
        '{ROW_KNOWN, 7'd1,   32'd100,        1'b1, 1, 6'd0, 1'b0},
        '{ROW_JOB,   7'd64,  32'hFFFF_FFFF,  1'b0, 0, 6'd0, 1'b0},
        '{ROW_JOB,   7'd64,  32'hFFFF_FFFF,  1'b0, 0, 6'd0, 1'b0},
        '{ROW_KNOWN, 7'd0,   32'd12345,      1'b0, 0, 6'd0, 1'b0},
        '{ROW_KNOWN, 7'd0,   32'd0,          1'b1, 0, 6'd0, 1'b0},
        '{ROW_KNOWN, 7'd1,   32'd0,          1'b0, 1, 6'd0, 1'b0},
        '{ROW_JOB,   7'd127, 32'hFFFF_FFFF,  1'b0, 0, 6'd0, 1'b0},
        '{ROW_JOB,   7'd3,   32'd2,          1'b0, 0, 6'd0, 1'b0},
        '{ROW_CFG,   7'd1,   32'd0,          1'b0, 0, 6'd0, 1'b0},
        '{ROW_KNOWN, 7'd127, 32'd7,          1'b1, 1, 6'd0, 1'b1},
        '{ROW_KNOWN, 7'd1,   32'hFFFF_FFFF,  1'b0, 1, 6'd0, 1'b0},
        '{ROW_KNOWN, 7'd1,   32'hFFFF_FFFF,  1'b0, 1, 6'd0, 1'b0},
        '{ROW_KNOWN, 7'd2,   32'd5,          1'b0, 1, 6'd0, 1'b1},
        '{ROW_CFG,   7'd0,   32'd0,          1'b0, 0, 6'd0, 1'b0},
        '{ROW_KNOWN, 7'd64,  32'd1,          1'b0, 1, 6'd0, 1'b1},
        '{ROW_CFG,   7'd127, 32'd0,          1'b0, 0, 6'd0, 1'b0},
        '{ROW_JOB,   7'd64,  32'h8000_0000,  1'b0, 0, 6'd0, 1'b0},
        '{ROW_CFG,   7'd65,  32'd0,          1'b0, 0, 6'd0, 1'b0},
        '{ROW_JOB,   7'd65,  32'h0000_FFFF,  1'b1, 0, 6'd0, 1'b0},
        '{ROW_CFG,   7'd2,   32'd0,          1'b0, 0, 6'd0, 1'b0},
        '{ROW_JOB,   7'd2,   32'd10,         1'b0, 0, 6'd0, 1'b0},
        '{ROW_JOB,   7'd3,   32'd9,          1'b0, 0, 6'd0, 1'b0},
        '{ROW_CFG,   7'd64,  32'd0,          1'b0, 0, 6'd0, 1'b0},
        '{ROW_JOB,   7'd5,   32'd50,         1'b0, 0, 6'd0, 1'b0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_W-1:0]      i_cfg_cores_in_use = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [THREAD_W-1:0]   i_thread_count = '0;
    logic [LOAD_W-1:0]     i_total_load = '0;
    logic                  i_round_start = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [CORE_IDX_W-1:0] o_core_index;
    logic                  o_last_of_job;
    logic                  o_truncated;

    // Predictor state.
    logic [LOAD_W-1:0]     core_loads [NCORES];
    logic [CFG_W-1:0]      cores_setting;
    t_placement            job_placements [RESULT_LIMIT];
    t_placement            due_placements [$];

    bit calm = 1'b0;
    bit hold_request = 1'b0;
    int mismatches = 0;
    int jobs_sent = 0;
    int empty_jobs = 0;
    int beats_checked = 0;
    int truncated_beats = 0;
    int cfg_writes = 0;

    least_loaded_core_assigner #(
        .MAX_CORES(DEF_MAX_CORES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_cores_in_use(i_cfg_cores_in_use),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_thread_count(i_thread_count),
        .i_total_load(i_total_load),
        .i_round_start(i_round_start),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_core_index(o_core_index),
        .o_last_of_job(o_last_of_job),
        .o_truncated(o_truncated)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("Timeout: %0d placements still outstanding.", due_placements.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Places the job on the predictor's core loads and fills job_placements.
    function automatic int place_job(input logic [THREAD_W-1:0] threads,
                                     input logic [LOAD_W-1:0] total, input logic round);
        int ncores;
        int placed;
        int best;
        bit found;
        bit taken [NCORES];
        logic [LOAD_W-1:0] share;
        logic [LOAD_W:0] sum;
        if (round) begin
            for (int c = 0; c < NCORES; c++) core_loads[c] = '0;
        end
        if (threads == 0) return 0;
        ncores = int'(cores_setting);
        if (ncores < 1) ncores = 1;
        if (ncores > NCORES) ncores = NCORES;
        placed = int'(threads);
        if (placed > ncores) placed = ncores;
        if (placed > RESULT_LIMIT) placed = RESULT_LIMIT;
        share = total / LOAD_W'(threads);
        for (int c = 0; c < NCORES; c++) taken[c] = 1'b0;
        for (int t = 0; t < placed; t++) begin
            found = 1'b0;
            best = 0;
            for (int c = 0; c < ncores; c++) begin
                if (!taken[c] && (!found || core_loads[c] < core_loads[best])) begin
                    best = c;
                    found = 1'b1;
                end
            end
            taken[best] = 1'b1;
            sum = {1'b0, core_loads[best]} + {1'b0, share};
            core_loads[best] = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];
            job_placements[t].core = CORE_IDX_W'(best);
            job_placements[t].last = (t + 1 == placed);
            job_placements[t].trunc = (int'(threads) > placed);
        end
        return placed;
    endfunction

    function automatic bit sender_gap();
        return !calm && ($urandom_range(99) < 6);
    endfunction

    function automatic bit count_mismatch();
        mismatches++;
        return mismatches <= REPORT_MAX;
    endfunction

    // Offers one job beat and, once accepted, queues its placements.
    task automatic run_job(input logic [THREAD_W-1:0] threads, input logic [LOAD_W-1:0] total,
                           input logic round, input bit known, input int n_known,
                           input t_placement known_beat);
        int n;
        while (sender_gap()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_thread_count <= threads;
        i_total_load <= total;
        i_round_start <= round;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n = place_job(threads, total, round);
        jobs_sent++;
        if (threads == 0) empty_jobs++;
        if (known) begin
            if (n_known != 0) due_placements = {due_placements, known_beat};
        end else begin
            for (int k = 0; k < n; k++) due_placements = {due_placements, job_placements[k]};
        end
    endtask

    // Stops offering jobs, waits for every placement, then lets a job that
    // gives no placement finish too.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (due_placements.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_cores(input logic [CFG_W-1:0] cores);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_cores_in_use <= cores;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cores_setting = cores;
        cfg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_job();
        int pick;
        logic [THREAD_W-1:0] threads;
        logic [LOAD_W-1:0] total;
        pick = $urandom_range(99);
        if (pick < 4) threads = '0;
        else if (pick < 82) threads = THREAD_W'($urandom_range(8, 1));
        else if (pick < 94) threads = THREAD_W'($urandom_range(64, 9));
        else threads = THREAD_W'($urandom_range(127, 65));
        pick = $urandom_range(99);
        if (pick < 40) total = $urandom();
        else if (pick < 70) total = LOAD_W'($urandom_range(1000));
        else if (pick < 80) total = '1;
        else if (pick < 88) total = '0;
        else total = $urandom() | 32'hC000_0000;
        run_job(threads, total, $urandom_range(99) < 10, 1'b0, 0, '0);
    endtask

    // Receiver: checks each accepted placement beat and drives ready.
    initial begin
        int hold_left;
        t_placement got;
        t_placement want;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                got = '{core: o_core_index, last: o_last_of_job, trunc: o_truncated};
                if (due_placements.size() == 0) begin
                    if (count_mismatch())
                        $display("Unexpected placement beat: core %0d last %0b trunc %0b",
                                 got.core, got.last, got.trunc);
                end else begin
                    want = due_placements.pop_front();
                    beats_checked++;
                    if (want.trunc) truncated_beats++;
                    if (got != want && count_mismatch())
                        $display({"Placement mismatch: expected core %0d last %0b trunc %0b,",
                                  " got core %0d last %0b trunc %0b"},
                                 want.core, want.last, want.trunc,
                                 got.core, got.last, got.trunc);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= calm || ($urandom_range(99) >= 6);
            end
        end
    end

    initial begin
        logic [CFG_W-1:0] phase_cores [PHASES];
        t_placement known_beat;
        for (int c = 0; c < NCORES; c++) core_loads[c] = '0;
        cores_setting = CORES_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                write_cores(directed_rows[r].value);
            end else begin
                known_beat = '{core: directed_rows[r].core, last: 1'b1,
                               trunc: directed_rows[r].trunc};
                run_job(directed_rows[r].value, directed_rows[r].load, directed_rows[r].round,
                        directed_rows[r].kind == ROW_KNOWN, directed_rows[r].n_known,
                        known_beat);
            end
        end

        phase_cores = '{7'd3, 7'd64, 7'd0, 7'd8, 7'd127, 7'd0, 7'd1, 7'd33};
        phase_cores[2] = CFG_W'($urandom_range(64, 1));
        phase_cores[5] = CFG_W'($urandom_range(127, 0));
        for (int p = 0; p < PHASES; p++) begin
            write_cores(phase_cores[p]);
            calm = (p == 3);
            for (int j = 0; j < PHASE_JOBS; j++) begin
                random_job();
                // Stall the receiver early in one phase so that jobs back up.
                if (p == 1 && j == 0) hold_request = 1'b1;
            end
        end
        calm = 1'b0;
        drain();

        $display("Covered %0d jobs (%0d with no threads) over %0d core-count writes,",
                 jobs_sent, empty_jobs, cfg_writes);
        $display("with %0d placement beats checked, %0d of them truncated.",
                 beats_checked, truncated_beats);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches.", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
